### rtl/core/bfha_pkg.sv
// ----------------------------------------------------------------------------
// bfha_pkg: shared types and codes for the best-fit heap allocator
// Status codes, operation codes, config indices, field widths and reset heap size.
// ----------------------------------------------------------------------------
`default_nettype none
package bfha_pkg;
    localparam int unsigned ADDR_W = 32;
    localparam int unsigned SIZE_W = 16;
    localparam int unsigned HB_W   = 17;
    localparam int unsigned CNT_W  = 8;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_LIMIT    = 2'd1,
        ST_FULL     = 2'd2,
        ST_NOTFOUND = 2'd3
    } t_status;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic CFG_BASE  = 1'b0;
    localparam logic CFG_BYTES = 1'b1;

    localparam logic [HB_W-1:0] HB_RESET = 17'd8192;
endpackage
`default_nettype wire

### rtl/core/bfha_table.sv
// ----------------------------------------------------------------------------
// bfha_table: block table memory (offset and size per entry)
// One write port and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none
module bfha_table #(
    parameter int unsigned DEPTH = 128,
    parameter int unsigned AW    = 7
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_we,
    input  wire logic [AW-1:0]         i_waddr,
    input  wire logic [32:0]           i_wdata,
    input  wire logic [AW-1:0]         i_raddr,
    output logic      [32:0]           o_rdata
);
    // {size[16:0], start[15:0]}
    logic [32:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

### rtl/core/best_fit_heap_allocator.sv
// ----------------------------------------------------------------------------
// best_fit_heap_allocator: best-fit allocator over a sorted block table
// Sequenced scan, shift and compact over one table memory.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one request per transfer: tuser = op (0 alloc, 1 free),
//   tdata = {addr[31:0], size[15:0]} (size in the low bits, 48 bits).
//   m_axis returns one result per request: tdata = {block_addr, status}
//   in the low 34 bits, then entries[41:34], table_full[42], zero pad to 48.
//   Config writes (index 0 heap_base, 1 heap_bytes) only while idle.
// Sequencing: one item at a time through a single table RAM with one read
//   and one write port. Allocate on a table that is neither empty nor full
//   scans all live entries, reads the predecessor of the chosen slot, then
//   shifts later entries up and writes the new block. Free searches for the
//   matching address, then compacts the entries after it.
//   s_axis_tready is low while an item is in work or its result waits.
// Reset: entry count zero, heap_base 0, heap_bytes 8192; no clearing pass,
//   table RAM entries beyond the live count are never used.
// Stall: the result stays on m_axis until taken; no new item meanwhile.
// ----------------------------------------------------------------------------
`default_nettype none
module best_fit_heap_allocator #(
    parameter int unsigned TABLE_DEPTH = 128
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_index,
    input  wire logic [31:0] i_cfg_wdata,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [47:0] s_axis_tdata,   // size[15:0], addr[47:16]
    input  wire logic        s_axis_tuser,   // op
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [47:0] m_axis_tdata         // status[1:0], block_addr[33:2],
                                             // entries[41:34], table_full[42]
);
    import bfha_pkg::*;

    localparam int unsigned AW  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int unsigned CW  = $clog2(TABLE_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

    typedef enum logic [3:0] {
        S_IDLE, S_DEC, S_SRD, S_SCMP, S_OFF, S_OCALC, S_PLACE,
        S_MRD, S_MWR, S_FRD, S_FCMP, S_CRD, S_CWR, S_DONE
    } t_state;

    t_state           r_state;
    logic [31:0]      r_base;
    logic [HB_W-1:0]  r_hbytes;
    logic [CW-1:0]    r_count;
    logic             r_op;
    logic [16:0]      r_sz;
    logic [31:0]      r_addr;
    logic [CW-1:0]    r_i;
    logic [CW-1:0]    r_slot;
    logic [17:0]      r_best;
    logic [15:0]      r_pstart;
    logic [16:0]      r_psize;
    logic [16:0]      r_off;
    logic [1:0]       r_status;
    logic [31:0]      r_baddr;

    logic             w_we;
    logic [AW-1:0]    w_waddr;
    logic [32:0]      w_wdata;
    logic [AW-1:0]    w_raddr;
    logic [32:0]      w_rdata;

    bfha_table #(.DEPTH(TABLE_DEPTH), .AW(AW)) u_tab (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wdata(w_wdata),
        .i_raddr(w_raddr),
        .o_rdata(w_rdata)
    );

    logic [15:0] w_rstart;
    logic [16:0] w_rsize;
    assign w_rstart = w_rdata[15:0];
    assign w_rsize  = w_rdata[32:16];

    // usable limit
    logic [16:0] w_hb;
    logic [16:0] w_limit;
    assign w_hb    = (r_hbytes > 17'd65536) ? 17'd65536 : r_hbytes;
    assign w_limit = (w_hb >= 17'd4) ? (w_hb - 17'd4) : 17'd0;

    // gap unit: start[i] - start[i-1] - size[i-1], signed
    logic signed [18:0] w_gap;
    assign w_gap = $signed({3'b0, w_rstart}) - $signed({3'b0, r_pstart})
                 - $signed({2'b0, r_psize});

    logic [17:0] w_end;
    assign w_end = {1'b0, r_off} + {1'b0, r_sz};

    // candidate offset right after the predecessor read from the table
    logic [16:0] w_off;
    logic [17:0] w_oend;
    assign w_off  = {1'b0, w_rstart} + w_rsize;
    assign w_oend = {1'b0, w_off} + {1'b0, r_sz};

    assign s_axis_tready = (r_state == S_IDLE) && !m_axis_tvalid;

    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_i[AW-1:0];
        w_wdata = w_rdata;
        w_raddr = r_i[AW-1:0];
        case (r_state)
            S_OFF:   w_raddr = AW'(r_slot - CW'(1));
            S_MRD:   w_raddr = AW'(r_i - CW'(1));
            S_MWR: begin
                w_we = 1'b1;
            end
            S_PLACE: begin
                w_we    = (w_end < {1'b0, w_limit});
                w_waddr = r_slot[AW-1:0];
                w_wdata = {r_sz, r_off[15:0]};
            end
            S_CRD:   w_raddr = AW'(r_i + CW'(1));
            S_CWR: begin
                w_we = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_base        <= '0;
            r_hbytes      <= HB_RESET;
            r_count       <= '0;
            m_axis_tvalid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_BASE) r_base <= i_cfg_wdata;
                else r_hbytes <= i_cfg_wdata[HB_W-1:0];
            end
            if (m_axis_tvalid && m_axis_tready) m_axis_tvalid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid && s_axis_tready) begin
                        r_op    <= s_axis_tuser;
                        r_sz    <= {1'b0, s_axis_tdata[15:0]} +
                                   {16'b0, s_axis_tdata[0]};
                        r_addr  <= s_axis_tdata[47:16];
                        r_i     <= '0;
                        r_state <= S_DEC;
                    end
                end
                S_DEC: begin
                    r_baddr <= '0;
                    if (r_op == OP_FREE) begin
                        r_state <= (r_count == '0) ? S_DONE : S_FRD;
                        r_status <= ST_NOTFOUND;
                    end else if (r_count == '0) begin
                        r_off  <= '0;
                        r_slot <= '0;
                        r_state <= S_PLACE;
                    end else if (r_count >= DEPTH_C) begin
                        r_status <= ST_FULL;
                        r_state  <= S_DONE;
                    end else begin
                        r_slot  <= r_count;
                        r_best  <= '1;
                        r_state <= S_SRD;
                    end
                end
                S_SRD: r_state <= S_SCMP;   // read entry r_i
                S_SCMP: begin
                    if (r_i != '0 && w_gap >= $signed({2'b0, r_sz})
                            && w_gap < $signed({1'b0, r_best})) begin
                        r_best <= w_gap[17:0];
                        r_slot <= r_i;
                    end
                    r_pstart <= w_rstart;
                    r_psize  <= w_rsize;
                    if (r_i + CW'(1) == r_count) begin
                        r_i     <= r_count;
                        r_state <= S_OFF;
                    end else begin
                        r_i     <= r_i + CW'(1);
                        r_state <= S_SRD;
                    end
                end
                // read predecessor of the chosen slot
                S_OFF: r_state <= S_OCALC;
                S_OCALC: begin
                    // limit check before any entry moves
                    r_off <= w_off;
                    r_i   <= r_count;
                    if (w_oend < {1'b0, w_limit}) begin
                        r_state <= S_MRD;
                    end else begin
                        r_status <= ST_LIMIT;
                        r_state  <= S_DONE;
                    end
                end
                S_MRD: begin
                    if (r_i == r_slot) r_state <= S_PLACE;
                    else r_state <= S_MWR;
                end
                S_MWR: begin
                    r_i     <= r_i - CW'(1);
                    r_state <= S_MRD;
                end
                S_PLACE: begin
                    if (w_end < {1'b0, w_limit}) begin
                        r_count  <= r_count + CW'(1);
                        r_status <= ST_OK;
                        r_baddr  <= r_base + {15'b0, r_off};
                    end else begin
                        r_status <= ST_LIMIT;
                    end
                    r_state <= S_DONE;
                end
                S_FRD: r_state <= S_FCMP;
                S_FCMP: begin
                    if (r_base + {16'b0, w_rstart} == r_addr) begin
                        r_status <= ST_OK;
                        r_count  <= r_count - CW'(1);
                        r_state  <= (r_i + CW'(1) == r_count) ? S_DONE : S_CRD;
                    end else if (r_i + CW'(1) == r_count) begin
                        r_state <= S_DONE;
                    end else begin
                        r_i     <= r_i + CW'(1);
                        r_state <= S_FRD;
                    end
                end
                S_CRD: r_state <= S_CWR;
                S_CWR: begin
                    if (r_i + CW'(1) == r_count) r_state <= S_DONE;
                    else begin
                        r_i     <= r_i + CW'(1);
                        r_state <= S_CRD;
                    end
                end
                S_DONE: begin
                    m_axis_tvalid <= 1'b1;
                    r_state       <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    logic [7:0] w_entries;
    assign w_entries = 8'(r_count);
    assign m_axis_tdata = {5'b0, (r_count >= DEPTH_C), w_entries, r_baddr, r_status};
endmodule
`default_nettype wire

### rtl/core/bfha_checker.sv
// ----------------------------------------------------------------------------
// bfha_checker: port-level checks for the allocator
// Handshake and result-shape properties.
// ----------------------------------------------------------------------------
`default_nettype none
module bfha_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [47:0] m_axis_tdata
);
    import bfha_pkg::*;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result dropped under stall");
    a_noacc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("request taken while result pending");
    a_fail0: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[1:0] != ST_OK |-> m_axis_tdata[33:2] == 32'd0)
        else $error("nonzero address on failure");
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("ready right after accept");
endmodule

bind best_fit_heap_allocator bfha_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
);
`default_nettype wire

### tb/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for best_fit_heap_allocator
// Drives allocate/free requests over the input stream with random gaps,
// predicts each result from a local copy of the block table, and checks the
// output stream field by field. Phases change heap base and size while idle.
// ----------------------------------------------------------------------------
`default_nettype none
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import bfha_pkg::*;

    localparam int DEPTH = 128;
    localparam longint CYCLE_LIMIT = 8000000;

    typedef struct packed {
        logic        op;
        logic [15:0] size;
        logic [31:0] addr;
    } t_req;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] block_addr;
        logic [7:0]  entries;
        logic        table_full;
    } t_rsp;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_index = 1'b0;
    logic [31:0] i_cfg_wdata = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata = '0;   // size[15:0], addr[47:16]
    logic        s_axis_tuser = 1'b0; // op
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;        // status, block_addr, entries, table_full

    best_fit_heap_allocator #(.TABLE_DEPTH(DEPTH)) uut (.*);

    always #1 i_clk = ~i_clk;

    // predictor state: offsets and sizes, sorted by offset
    logic [31:0] heap_base_m;
    logic [16:0] heap_bytes_m;
    logic [15:0] blk_off [DEPTH];
    logic [16:0] blk_len [DEPTH];
    int          live_cnt;

    t_req        pending_reqs[$];
    t_rsp        expected_rsps[$];
    int          errors = 0;
    int          sent = 0, got = 0, n_ok = 0, n_fail = 0;
    longint      cycles = 0;

    // transfer flags captured at the rising edge
    logic s_axis_tready_q = 1'b0;
    logic m_acc_q = 1'b0;

    function automatic t_rsp predict_alloc(logic [15:0] req_size);
        t_rsp        r;
        logic [16:0] sz;
        longint      lim, best, gap, off;
        int          slot;
        lim  = heap_bytes_m > 17'd65536 ? 65536 : heap_bytes_m;
        lim  = lim >= 4 ? lim - 4 : 0;
        sz   = {1'b0, req_size} + req_size[0];
        r    = '0;
        if (live_cnt == 0) begin
            if (longint'(sz) >= lim) begin
                r.status = ST_LIMIT;
            end else begin
                blk_off[0] = '0; blk_len[0] = sz; live_cnt = 1;
                r.status = ST_OK; r.block_addr = heap_base_m;
            end
        end else if (live_cnt >= DEPTH) begin
            r.status = ST_FULL;
        end else begin
            best = 64'hFFFF_FFFF;
            slot = live_cnt;
            for (int i = 1; i < live_cnt; i++) begin
                gap = longint'(blk_off[i]) - longint'(blk_off[i-1])
                    - longint'(blk_len[i-1]);
                if (gap >= longint'(sz) && gap < best) begin
                    best = gap; slot = i;
                end
            end
            off = longint'(blk_off[slot-1]) + longint'(blk_len[slot-1]);
            if (off + longint'(sz) >= lim) begin
                r.status = ST_LIMIT;
            end else begin
                for (int i = live_cnt; i > slot; i--) begin
                    blk_off[i] = blk_off[i-1]; blk_len[i] = blk_len[i-1];
                end
                blk_off[slot] = off[15:0]; blk_len[slot] = sz;
                live_cnt++;
                r.status = ST_OK;
                r.block_addr = heap_base_m + off[31:0];
            end
        end
        r.entries    = 8'(live_cnt);
        r.table_full = (live_cnt >= DEPTH);
        return r;
    endfunction

    function automatic t_rsp predict_free(logic [31:0] a);
        t_rsp r;
        r = '0;
        r.status = ST_NOTFOUND;
        for (int i = 0; i < live_cnt; i++) begin
            if (heap_base_m + blk_off[i] == a) begin
                live_cnt--;
                for (int j = i; j < live_cnt; j++) begin
                    blk_off[j] = blk_off[j+1]; blk_len[j] = blk_len[j+1];
                end
                r.status = ST_OK;
                break;
            end
        end
        r.entries    = 8'(live_cnt);
        r.table_full = (live_cnt >= DEPTH);
        return r;
    endfunction

    // driver: one transfer per queued request, random gap after each
    int src_gap = 0;
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!s_axis_tvalid || s_axis_tready_q) begin
                if (src_gap > 0) begin
                    src_gap <= src_gap - 1;
                    s_axis_tvalid <= 1'b0;
                end else if (pending_reqs.size() > 0) begin
                    t_req q;
                    q = pending_reqs.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tuser  <= q.op;
                    s_axis_tdata  <= {q.addr, q.size};
                    src_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        s_axis_tready_q <= s_axis_tvalid && s_axis_tready;
        m_acc_q         <= m_axis_tvalid && m_axis_tready;
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            t_req q;
            q = {s_axis_tuser, s_axis_tdata[15:0], s_axis_tdata[47:16]};
            expected_rsps.push_back(q.op == OP_ALLOC ? predict_alloc(q.size)
                                                     : predict_free(q.addr));
            sent++;
        end
    end

    // sink: after each transfer draw how many cycles to hold ready low
    int sink_gap = 0;
    always @(negedge i_clk) begin
        int g;
        if (i_rst_n) begin
            if (m_acc_q) g = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
            else g = sink_gap;
            if (g > 0) begin
                sink_gap <= g - 1;
                m_axis_tready <= 1'b0;
            end else begin
                sink_gap <= 0;
                m_axis_tready <= 1'b1;
            end
        end
    end

    // monitor: compare each result with the oldest prediction
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            t_rsp act, exp_r;
            act.status     = m_axis_tdata[1:0];
            act.block_addr = m_axis_tdata[33:2];
            act.entries    = m_axis_tdata[41:34];
            act.table_full = m_axis_tdata[42];
            got++;
            if (expected_rsps.size() == 0) begin
                $display("%0t: result with none expected: %h", $realtime, m_axis_tdata);
                errors++;
            end else begin
                exp_r = expected_rsps.pop_front();
                if (exp_r.status == ST_OK) n_ok++; else n_fail++;
                if (act.status !== exp_r.status) begin
                    $display("%0t: status exp %0d act %0d", $realtime,
                             exp_r.status, act.status);
                    errors++;
                end
                if (act.block_addr !== exp_r.block_addr) begin
                    $display("%0t: block_addr exp %h act %h", $realtime,
                             exp_r.block_addr, act.block_addr);
                    errors++;
                end
                if (act.entries !== exp_r.entries) begin
                    $display("%0t: entries exp %0d act %0d", $realtime,
                             exp_r.entries, act.entries);
                    errors++;
                end
                if (act.table_full !== exp_r.table_full) begin
                    $display("%0t: table_full exp %0d act %0d", $realtime,
                             exp_r.table_full, act.table_full);
                    errors++;
                end
            end
        end
        if (cycles > CYCLE_LIMIT) begin
            $display("best_fit_heap_allocator verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    task automatic push_alloc(logic [15:0] sz);
        pending_reqs.push_back(t_req'{op: OP_ALLOC, size: sz, addr: $urandom()});
    endtask

    task automatic push_free(logic [31:0] a);
        pending_reqs.push_back(t_req'{op: OP_FREE, size: 16'($urandom()), addr: a});
    endtask

    task automatic wait_drained();
        while (pending_reqs.size() > 0 || s_axis_tvalid || expected_rsps.size() > 0)
            @(posedge i_clk);
        repeat (2 * DEPTH + 20) @(posedge i_clk);
    endtask

    task automatic write_cfg(logic idx, logic [31:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1; i_cfg_index <= idx; i_cfg_wdata <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_BASE) heap_base_m = val;
        else heap_bytes_m = val[16:0];
    endtask

    // random mix: mostly small allocations, frees aimed at probable blocks
    task automatic random_phase(int n, int big_pct);
        logic [31:0] a;
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(0, 99) < 55) begin
                if ($urandom_range(0, 99) < big_pct) push_alloc(16'($urandom()));
                else push_alloc(16'($urandom_range(0, 300)));
            end else begin
                // guess at an address in the low heap, or fully random
                case ($urandom_range(0, 3))
                    0: a = $urandom();
                    1: a = heap_base_m;
                    default: a = heap_base_m + ($urandom_range(0, 2000) & ~32'h1);
                endcase
                push_free(a);
            end
        end
    endtask

    // frees that hit: issue after drain, using the predictor's table
    task automatic free_some(int n);
        for (int k = 0; k < n && live_cnt > 0; k++) begin
            int idx;
            idx = $urandom_range(0, live_cnt - 1);
            push_free(heap_base_m + blk_off[idx]);
            wait_drained();
        end
    endtask

    initial begin
        heap_base_m  = '0;
        heap_bytes_m = HB_RESET;
        live_cnt     = 0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty-table free, zero size, odd size, extremes
        push_free(32'hFFFF_FFFF);
        push_alloc(16'd0);
        push_alloc(16'd0);
        push_alloc(16'd1);
        push_alloc(16'd7);
        push_free(32'd0);
        push_alloc(16'd0);
        push_alloc(16'hFFFF);
        push_free(32'd2);
        push_alloc(16'd4);
        push_free(32'd6);
        push_alloc(16'd2);
        wait_drained();

        // tiny heap: limit reached on empty table, and below four bytes
        write_cfg(CFG_BYTES, 32'd8);
        write_cfg(CFG_BASE, 32'hFFFF_FFF0);
        free_some(DEPTH);
        push_alloc(16'd3);
        push_alloc(16'd4);
        push_alloc(16'd2);
        push_free(32'hFFFF_FFF0);
        wait_drained();
        write_cfg(CFG_BYTES, 32'h1FFFF);   // above 65536, clamped
        write_cfg(CFG_BASE, 32'hFFFF_0000);
        push_alloc(16'hFFFA);
        push_alloc(16'hFFFB);
        push_alloc(16'd10);
        wait_drained();
        write_cfg(CFG_BYTES, 32'd2);
        push_alloc(16'd0);
        wait_drained();
        free_some(DEPTH);

        // fill the table with small blocks to reach table full
        write_cfg(CFG_BYTES, 32'd65536);
        write_cfg(CFG_BASE, 32'h1234_5678);
        for (int k = 0; k < DEPTH + 3; k++) push_alloc(16'($urandom_range(0, 9)));
        wait_drained();
        free_some(10);
        for (int k = 0; k < 12; k++) push_alloc(16'($urandom_range(0, 4)));
        wait_drained();

        // random phases over several heap settings
        random_phase(300, 2);
        wait_drained();
        free_some(60);
        write_cfg(CFG_BASE, $urandom());
        write_cfg(CFG_BYTES, 32'd4096);
        random_phase(300, 5);
        wait_drained();
        free_some(40);
        write_cfg(CFG_BASE, 32'd0);
        write_cfg(CFG_BYTES, 32'd600);
        random_phase(300, 1);
        wait_drained();
        free_some(DEPTH);
        write_cfg(CFG_BASE, 32'hFFFF_FFFF);
        write_cfg(CFG_BYTES, 32'd65536);
        random_phase(250, 10);
        wait_drained();

        $display("Ran %0d requests (%0d ok, %0d refused) over several heap bases",
                 sent, n_ok, n_fail);
        $display("and sizes, including empty, full and clamped heaps.");
        if (errors == 0 && got == sent) begin
            $display("best_fit_heap_allocator verification clean");
        end else begin
            $display("best_fit_heap_allocator verification failed");
        end
        $finish;
    end
endmodule
`default_nettype wire

### sim.f
rtl/core/bfha_pkg.sv
rtl/core/bfha_table.sv
rtl/core/best_fit_heap_allocator.sv
rtl/core/bfha_checker.sv
tb/tb.sv
